[sv/cscol_pkg.sv]
package cscol_pkg;

  localparam int CoordBits = 16;
  localparam int RadBits   = CoordBits - 1;
  localparam int DiffBits  = CoordBits + 2;
  localparam int NumSeg    = 4;

  localparam logic [1:0] KindCircle = 2'd0;
  localparam logic [1:0] KindRect   = 2'd1;
  localparam logic [1:0] KindTri    = 2'd2;
  localparam logic [1:0] KindSeg    = 2'd3;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits+1:0] pt_t;

  typedef struct packed {
    pt_t ax;
    pt_t ay;
    pt_t bx;
    pt_t by;
  } seg_t;

endpackage

[sv/circle_shape_collision_test_core.sv]
// hit_valid_o is start delayed along the vld_q shift register
// throughput: one query per cycle, busy is always low
// the receiver cannot stall, so results never back up
// reset: asynchronous active low, clears all valid bits
module circle_shape_collision_test_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic [1:0] kind_i,
  input  cscol_pkg::coord_t circle_x_i,
  input  cscol_pkg::coord_t circle_y_i,
  input  logic [cscol_pkg::RadBits-1:0] circle_r_i,
  input  cscol_pkg::coord_t p0_x_i,
  input  cscol_pkg::coord_t p0_y_i,
  input  cscol_pkg::coord_t p1_x_i,
  input  cscol_pkg::coord_t p1_y_i,
  input  cscol_pkg::coord_t p2_x_i,
  input  cscol_pkg::coord_t p2_y_i,
  input  logic [cscol_pkg::RadBits-1:0] other_r_i,
  output logic hit_valid_o,
  output logic hit_o
);

  localparam int Lat = 5;
  localparam int Z = 2 * cscol_pkg::DiffBits + 2;
  localparam int E = cscol_pkg::DiffBits + 1;
  localparam int S = 2 * cscol_pkg::CoordBits + 2;
  localparam int R = cscol_pkg::CoordBits;
  localparam int Q = 2 * cscol_pkg::CoordBits;

  cscol_pkg::seg_t seg_q [cscol_pkg::NumSeg];
  cscol_pkg::pt_t cx_q, cy_q;
  logic [Q-1:0] r2_q;
  logic [1:0] kind_q;
  logic [3:0] segen_q;
  logic in_q;
  logic [Lat-1:0] vld_q;
  logic [1:0] kind_p [Lat-1];
  logic [3:0] segen_p [Lat-1];
  logic in_p [Lat-1];
  logic [cscol_pkg::NumSeg-1:0] near;

  cscol_pkg::pt_t ax, ay, bx, by, qx, qy, cx, cy, x1, y1, xlo, xhi, ylo, yhi;
  logic signed [E-1:0] ddx, ddy;
  logic [S-1:0] rs2, dsq;
  logic [R-1:0] rsum;
  logic signed [Z-1:0] z [6];
  logic insd;

  assign busy = 1'b0;

  always_comb begin
    ax = cscol_pkg::pt_t'(p0_x_i); ay = cscol_pkg::pt_t'(p0_y_i);
    bx = cscol_pkg::pt_t'(p1_x_i); by = cscol_pkg::pt_t'(p1_y_i);
    qx = cscol_pkg::pt_t'(p2_x_i); qy = cscol_pkg::pt_t'(p2_y_i);
    cx = cscol_pkg::pt_t'(circle_x_i); cy = cscol_pkg::pt_t'(circle_y_i);
    x1 = ax + bx; y1 = ay + by;
    xlo = (bx < 0) ? x1 : ax; xhi = (bx < 0) ? ax : x1;
    ylo = (by < 0) ? y1 : ay; yhi = (by < 0) ? ay : y1;
    ddx = E'(ax) - E'(cx);
    ddy = E'(ay) - E'(cy);
    dsq = S'(ddx * ddx) + S'(ddy * ddy);
    rsum = R'(circle_r_i) + R'(other_r_i);
    rs2 = S'(rsum * rsum);
    z[0] = Z'((bx - ax) * (cy - ay)) - Z'((by - ay) * (cx - ax));
    z[1] = Z'((bx - ax) * (qy - ay)) - Z'((by - ay) * (qx - ax));
    z[2] = Z'((qx - bx) * (cy - by)) - Z'((qy - by) * (cx - bx));
    z[3] = Z'((qx - bx) * (ay - by)) - Z'((qy - by) * (ax - bx));
    z[4] = Z'((ax - qx) * (cy - qy)) - Z'((ay - qy) * (cx - qx));
    z[5] = Z'((ax - qx) * (by - qy)) - Z'((ay - qy) * (bx - qx));
    insd = 1'b1;
    for (int i = 0; i < 3; i++) begin
      insd = insd && !((z[2*i] < 0) != (z[2*i+1] < 0) && z[2*i] != 0 && z[2*i+1] != 0);
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx; cy_q <= cy;
    r2_q <= Q'(circle_r_i * circle_r_i);
    kind_q <= kind_i;
    case (kind_i)
      cscol_pkg::KindCircle: begin
        in_q <= dsq < rs2;
        segen_q <= 4'b0000;
        seg_q[0] <= '0; seg_q[1] <= '0; seg_q[2] <= '0; seg_q[3] <= '0;
      end
      cscol_pkg::KindRect: begin
        in_q <= cx <= xhi && cx >= xlo && cy <= yhi && cy >= ylo;
        segen_q <= 4'b1111;
        seg_q[0] <= '{ax, ay, x1, ay};
        seg_q[1] <= '{x1, ay, x1, y1};
        seg_q[2] <= '{x1, y1, ax, y1};
        seg_q[3] <= '{ax, y1, ax, ay};
      end
      cscol_pkg::KindTri: begin
        in_q <= insd;
        segen_q <= 4'b0111;
        seg_q[0] <= '{ax, ay, bx, by};
        seg_q[1] <= '{bx, by, qx, qy};
        seg_q[2] <= '{qx, qy, ax, ay};
        seg_q[3] <= '0;
      end
      default: begin
        in_q <= 1'b0;
        segen_q <= 4'b0001;
        seg_q[0] <= '{ax, ay, bx, by};
        seg_q[1] <= '0; seg_q[2] <= '0; seg_q[3] <= '0;
      end
    endcase
    kind_p[0] <= kind_q;
    segen_p[0] <= segen_q;
    in_p[0] <= in_q;
    for (int i = 1; i < Lat - 1; i++) begin
      kind_p[i] <= kind_p[i-1];
      segen_p[i] <= segen_p[i-1];
      in_p[i] <= in_p[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  for (genvar g = 0; g < cscol_pkg::NumSeg; g++) begin : g_seg
    cscol_seg_unit u_seg (
      .clk_i, .seg_i(seg_q[g]), .cx_i(cx_q), .cy_i(cy_q),
      .r2_i(r2_q), .near_o(near[g])
    );
  end

  assign hit_valid_o = vld_q[Lat-1];
  assign hit_o = in_p[Lat-2] || |(near & segen_p[Lat-2]);

  a_busy: assert property (@(posedge clk_i) !busy) else $error("busy");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##5 hit_valid_o) else $error("latency");
  a_circ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_valid_o && kind_p[Lat-2] == cscol_pkg::KindCircle) |-> (hit_o == in_p[Lat-2]))
    else $error("circle");

endmodule

[sv/cscol_seg_unit.sv]
module cscol_seg_unit (
  input  logic clk_i,
  input  cscol_pkg::seg_t seg_i,
  input  cscol_pkg::pt_t cx_i,
  input  cscol_pkg::pt_t cy_i,
  input  logic [2*cscol_pkg::CoordBits-1:0] r2_i,
  output logic near_o
);

  localparam int D = cscol_pkg::DiffBits + 1;
  localparam int P = 2 * D + 1;
  localparam int H = P / 2;
  localparam int M = 2 * H;
  localparam int W = 2 * M;

  logic signed [D-1:0] dx, dy, wx, wy, vx, vy;
  logic signed [P-1:0] len_d, t_d, cr_d, da_d, db_d;
  logic signed [P-1:0] len_q, t_q, cr_q, da_q, db_q;
  logic signed [P:0] r2_q;
  logic [M-1:0] cm, rm, lm;
  logic [M-1:0] pc_q [3];
  logic [M-1:0] pr_q [4];
  logic [W-1:0] crsq_q, rl_q;
  logic sel_a_q, sel_b_q, sa2_q, sb2_q;
  logic da_lt_q, db_lt_q, da2_q, db2_q;
  logic near_q;

  always_comb begin
    dx = D'(seg_i.bx) - D'(seg_i.ax);
    dy = D'(seg_i.by) - D'(seg_i.ay);
    wx = D'(cx_i) - D'(seg_i.ax);
    wy = D'(cy_i) - D'(seg_i.ay);
    vx = D'(cx_i) - D'(seg_i.bx);
    vy = D'(cy_i) - D'(seg_i.by);
    len_d = P'(dx * dx) + P'(dy * dy);
    t_d = P'(wx * dx) + P'(wy * dy);
    cr_d = P'(dx * wy) - P'(dy * wx);
    da_d = P'(wx * wx) + P'(wy * wy);
    db_d = P'(vx * vx) + P'(vy * vy);
  end

  // magnitudes split in halves for the wide products
  always_comb begin
    cm = cr_q[P-1] ? M'(-cr_q) : M'(cr_q);
    rm = M'(r2_q);
    lm = M'(len_q);
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    t_q <= t_d;
    cr_q <= cr_d;
    da_q <= da_d;
    db_q <= db_d;
    r2_q <= $signed({1'b0, P'(r2_i)});
    sel_a_q <= (len_q == '0) || !(t_q > 0);
    sel_b_q <= !(t_q < len_q);
    pc_q[0] <= M'(cm[M-1:H]) * M'(cm[M-1:H]);
    pc_q[1] <= M'(cm[M-1:H]) * M'(cm[H-1:0]);
    pc_q[2] <= M'(cm[H-1:0]) * M'(cm[H-1:0]);
    pr_q[0] <= M'(rm[M-1:H]) * M'(lm[M-1:H]);
    pr_q[1] <= M'(rm[M-1:H]) * M'(lm[H-1:0]);
    pr_q[2] <= M'(rm[H-1:0]) * M'(lm[M-1:H]);
    pr_q[3] <= M'(rm[H-1:0]) * M'(lm[H-1:0]);
    da_lt_q <= da_q < r2_q;
    db_lt_q <= db_q < r2_q;
    crsq_q <= (W'(pc_q[0]) << M) + (W'(pc_q[1]) << (H + 1)) + W'(pc_q[2]);
    rl_q <= (W'(pr_q[0]) << M) + (W'(pr_q[1]) << H) + (W'(pr_q[2]) << H) + W'(pr_q[3]);
    sa2_q <= sel_a_q;
    sb2_q <= sel_b_q;
    da2_q <= da_lt_q;
    db2_q <= db_lt_q;
    near_q <= sa2_q ? da2_q : (sb2_q ? db2_q : (crsq_q < rl_q));
  end

  assign near_o = near_q;

endmodule
